/* sv/bgm_pkg.sv */
// shared types, codes and reset constants of the button gesture / mode / led controller
// no dependencies; used by bgm_csr, bgm_engine and the core
`default_nettype none

package bgm_pkg;

   localparam int COUNTER_BITS_DEF = 32;
   localparam int CFG_BITS         = 16;
   localparam int TOTAL_BITS       = 32;
   localparam int ADDR_BITS        = 5;
   localparam int DATA_BITS        = 32;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_LONG_PRESS  = 3'd0;
   localparam logic [2:0] REG_SHORT_PRESS = 3'd1;
   localparam logic [2:0] REG_BLINK_IDLE  = 3'd2;
   localparam logic [2:0] REG_BLINK_ACT   = 3'd3;
   localparam logic [2:0] REG_BLINK_ALERT = 3'd4;

   localparam logic [CFG_BITS-1:0] LONG_PRESS_RST  = 16'd1000;
   localparam logic [CFG_BITS-1:0] SHORT_PRESS_RST = 16'd50;
   localparam logic [CFG_BITS-1:0] BLINK_IDLE_RST  = 16'd1000;
   localparam logic [CFG_BITS-1:0] BLINK_ACT_RST   = 16'd250;
   localparam logic [CFG_BITS-1:0] BLINK_ALERT_RST = 16'd100;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_CMD  = 1'b1;

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_ACTIVE = 2'd1;
   localparam logic [1:0] MODE_ALERT  = 2'd2;
   localparam logic [1:0] MODE_CONFIG = 2'd3;

   localparam logic [1:0] GEST_NONE  = 2'd0;
   localparam logic [1:0] GEST_SHORT = 2'd1;
   localparam logic [1:0] GEST_LONG  = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_HELD = 3'b010,
      PH_LONG = 3'b100
   } bgm_phase_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] long_press_ticks;
      logic [CFG_BITS-1:0] short_press_ticks;
      logic [CFG_BITS-1:0] blink_idle_ticks;
      logic [CFG_BITS-1:0] blink_active_ticks;
      logic [CFG_BITS-1:0] blink_alert_ticks;
   } bgm_cfg_type;

   typedef struct packed {
      logic                  led_on;
      logic [1:0]            mode;
      logic [1:0]            gesture;
      logic [TOTAL_BITS-1:0] press_count;
      logic [TOTAL_BITS-1:0] command_count;
   } bgm_result_type;

endpackage

`default_nettype wire

/* sv/bgm_req_if.sv */
// input channel: ticks with button level, and mode set commands
// depends on nothing
`default_nettype none

interface bgm_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic       button_level;
   logic [1:0] new_mode;

   modport source (output valid, output kind, output button_level, output new_mode,
                   input ready);
   modport sink   (input valid, input kind, input button_level, input new_mode,
                   output ready);
endinterface

`default_nettype wire

/* sv/bgm_rsp_if.sv */
// result channel: led level, mode, gesture and running totals
// depends on nothing
`default_nettype none

interface bgm_rsp_if;
   logic        valid;
   logic        ready;
   logic        led_on;
   logic [1:0]  mode;
   logic [1:0]  gesture;
   logic [31:0] press_count;
   logic [31:0] command_count;

   modport source (output valid, output led_on, output mode, output gesture,
                   output press_count, output command_count, input ready);
   modport sink   (input valid, input led_on, input mode, input gesture,
                   input press_count, input command_count, output ready);
endinterface

`default_nettype wire

/* sv/bgm_csr.sv */
// apb-style register file for the press thresholds and blink intervals
// depends on bgm_pkg
`default_nettype none

module bgm_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [bgm_pkg::ADDR_BITS-1:0] csr_paddr,
   input  wire logic [bgm_pkg::DATA_BITS-1:0] csr_pwdata,
   output logic      [bgm_pkg::DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready,
   output bgm_pkg::bgm_cfg_type               cfg
);

   bgm_pkg::bgm_cfg_type cfg_ff;
   logic [2:0]           reg_index;
   logic                 wr_en;
   logic [bgm_pkg::CFG_BITS-1:0] wdata;
   logic [bgm_pkg::CFG_BITS-1:0] rdata;

   assign reg_index  = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign wdata      = csr_pwdata[bgm_pkg::CFG_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks   <= bgm_pkg::LONG_PRESS_RST;
         cfg_ff.short_press_ticks  <= bgm_pkg::SHORT_PRESS_RST;
         cfg_ff.blink_idle_ticks   <= bgm_pkg::BLINK_IDLE_RST;
         cfg_ff.blink_active_ticks <= bgm_pkg::BLINK_ACT_RST;
         cfg_ff.blink_alert_ticks  <= bgm_pkg::BLINK_ALERT_RST;
      end else if (wr_en) begin
         unique case (reg_index)
            bgm_pkg::REG_LONG_PRESS:  cfg_ff.long_press_ticks   <= wdata;
            bgm_pkg::REG_SHORT_PRESS: cfg_ff.short_press_ticks  <= wdata;
            bgm_pkg::REG_BLINK_IDLE:  cfg_ff.blink_idle_ticks   <= wdata;
            bgm_pkg::REG_BLINK_ACT:   cfg_ff.blink_active_ticks <= wdata;
            bgm_pkg::REG_BLINK_ALERT: cfg_ff.blink_alert_ticks  <= wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         bgm_pkg::REG_LONG_PRESS:  rdata = cfg_ff.long_press_ticks;
         bgm_pkg::REG_SHORT_PRESS: rdata = cfg_ff.short_press_ticks;
         bgm_pkg::REG_BLINK_IDLE:  rdata = cfg_ff.blink_idle_ticks;
         bgm_pkg::REG_BLINK_ACT:   rdata = cfg_ff.blink_active_ticks;
         bgm_pkg::REG_BLINK_ALERT: rdata = cfg_ff.blink_alert_ticks;
         default:                  rdata = '0;
      endcase
   end

   assign csr_prdata = {{(bgm_pkg::DATA_BITS-bgm_pkg::CFG_BITS){1'b0}}, rdata};
   assign cfg        = cfg_ff;

endmodule

`default_nettype wire

/* sv/bgm_engine.sv */
// press classifier, mode register and led blinker state; one item per cycle while fire is high
// depends on bgm_pkg
`default_nettype none

module bgm_engine #(
   parameter int COUNTER_BITS = bgm_pkg::COUNTER_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire logic                 kind,
   input  wire logic                 button_level,
   input  wire logic [1:0]           new_mode,
   input  wire bgm_pkg::bgm_cfg_type cfg,
   output bgm_pkg::bgm_result_type   result
);

   logic [COUNTER_BITS-1:0] tick_ff, tick_in;
   logic [COUNTER_BITS-1:0] start_ff, start_in;
   logic [COUNTER_BITS-1:0] toggle_ff, toggle_in;
   bgm_pkg::bgm_phase_type  phase_ff, phase_in;
   logic [1:0]              mode_ff, mode_in;
   logic                    led_ff, led_in;
   logic [bgm_pkg::TOTAL_BITS-1:0] press_ff, press_in;
   logic [bgm_pkg::TOTAL_BITS-1:0] cmd_ff, cmd_in;

   logic                    is_tick, released, new_press, check_held;
   logic [COUNTER_BITS-1:0] tick_inc, held, elapsed;
   logic [bgm_pkg::CFG_BITS-1:0] interval;
   logic                    reach_long, reach_short;
   logic [1:0]              gesture;

   assign is_tick  = (kind == bgm_pkg::KIND_TICK);
   assign released = button_level;
   assign tick_inc = tick_ff + COUNTER_BITS'(1);
   assign tick_in  = is_tick ? tick_inc : tick_ff;

   // a press starts whenever the level is low outside the held phases
   assign new_press = (phase_ff != bgm_pkg::PH_HELD) && (phase_ff != bgm_pkg::PH_LONG) &&
                      !released;

   // held time: a press starting on this tick has held zero
   assign held        = new_press ? '0 : (tick_inc - start_ff);
   assign reach_long  = held >= COUNTER_BITS'(cfg.long_press_ticks);
   assign reach_short = held >= COUNTER_BITS'(cfg.short_press_ticks);

   always_comb begin
      check_held = 1'b0;
      start_in   = start_ff;
      phase_in   = phase_ff;
      gesture    = bgm_pkg::GEST_NONE;
      unique case (phase_ff)
         bgm_pkg::PH_HELD: check_held = 1'b1;
         bgm_pkg::PH_LONG: begin
            if (released) phase_in = bgm_pkg::PH_IDLE;
         end
         default: begin
            if (!released) begin
               check_held = 1'b1;
               start_in   = tick_inc;
               phase_in   = bgm_pkg::PH_HELD;
            end
         end
      endcase
      if (check_held) begin
         if (reach_long) begin
            gesture = bgm_pkg::GEST_LONG;
            if (released) begin
               phase_in = bgm_pkg::PH_IDLE;
            end else begin
               phase_in = bgm_pkg::PH_LONG;
            end
         end else if (released) begin
            gesture  = reach_short ? bgm_pkg::GEST_SHORT : bgm_pkg::GEST_NONE;
            phase_in = bgm_pkg::PH_IDLE;
         end
      end
      if (!is_tick) begin
         gesture  = bgm_pkg::GEST_NONE;
         start_in = start_ff;
         phase_in = phase_ff;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      press_in = press_ff;
      cmd_in   = cmd_ff;
      if (!is_tick) begin
         mode_in = new_mode;
         cmd_in  = cmd_ff + bgm_pkg::TOTAL_BITS'(1);
      end else if (gesture == bgm_pkg::GEST_SHORT) begin
         mode_in  = mode_ff + 2'd1;
         press_in = press_ff + bgm_pkg::TOTAL_BITS'(1);
      end else if (gesture == bgm_pkg::GEST_LONG) begin
         mode_in  = bgm_pkg::MODE_ALERT;
         press_in = press_ff + bgm_pkg::TOTAL_BITS'(1);
      end
   end

   assign elapsed = tick_in - toggle_ff;

   always_comb begin
      case (mode_in)
         bgm_pkg::MODE_IDLE:   interval = cfg.blink_idle_ticks;
         bgm_pkg::MODE_ACTIVE: interval = cfg.blink_active_ticks;
         default:              interval = cfg.blink_alert_ticks;
      endcase
      led_in    = led_ff;
      toggle_in = toggle_ff;
      if (mode_in == bgm_pkg::MODE_CONFIG) begin
         led_in = 1'b1;
      end else if (elapsed >= COUNTER_BITS'(interval)) begin
         led_in    = ~led_ff;
         toggle_in = tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         start_ff  <= '0;
         toggle_ff <= '0;
         phase_ff  <= bgm_pkg::PH_IDLE;
         mode_ff   <= bgm_pkg::MODE_IDLE;
         led_ff    <= 1'b0;
         press_ff  <= '0;
         cmd_ff    <= '0;
      end else if (fire) begin
         tick_ff   <= tick_in;
         start_ff  <= start_in;
         toggle_ff <= toggle_in;
         phase_ff  <= phase_in;
         mode_ff   <= mode_in;
         led_ff    <= led_in;
         press_ff  <= press_in;
         cmd_ff    <= cmd_in;
      end
   end

   assign result.led_on        = led_in;
   assign result.mode          = mode_in;
   assign result.gesture       = gesture;
   assign result.press_count   = press_in;
   assign result.command_count = cmd_in;

endmodule

`default_nettype wire

/* sv/button_gesture_mode_led_controller_core.sv */
// top level of the button gesture / mode / led controller
// depends on bgm_pkg, bgm_req_if, bgm_rsp_if, bgm_csr, bgm_engine
//
// req carries millisecond ticks (kind 0, with the active-low button level) and
// mode set commands (kind 1, with new_mode). every accepted item yields exactly
// one result on rsp: led level, mode, gesture seen on this item, press total and
// command total. thresholds and blink intervals sit in five 16-bit registers on
// the csr apb port at byte addresses 0, 4, 8, 12, 16; write them only while idle.
// an accepted item lands in an input register, the engine evaluates it
// combinationally and the result register holds it: rsp.valid rises once the
// item has passed the input register and the result register, later if rsp
// stalls. one item per cycle sustained while rsp.ready stays high. if rsp
// stalls, the result register holds, the input register fills, and req.ready
// drops until rsp.ready returns.
// reset (synchronous) clears time counters, totals, mode (idle), led (off),
// the press phase and the valid bits of both pipeline registers, and loads the
// registers' defaults (1000, 50, 1000, 250, 100). no clearing pass is needed.
`default_nettype none

module button_gesture_mode_led_controller_core #(
   parameter int COUNTER_BITS = bgm_pkg::COUNTER_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bgm_req_if.sink                            req,
   bgm_rsp_if.source                          rsp,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [bgm_pkg::ADDR_BITS-1:0] csr_paddr,
   input  wire logic [bgm_pkg::DATA_BITS-1:0] csr_pwdata,
   output logic      [bgm_pkg::DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   bgm_pkg::bgm_cfg_type    cfg;
   bgm_pkg::bgm_result_type result;
   bgm_pkg::bgm_result_type rsp_ff;

   logic       in_valid_ff, in_valid_in;
   logic       kind_ff, level_ff;
   logic [1:0] new_mode_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance, fire, req_xfer;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign fire      = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;
   assign req_xfer  = req.valid && req.ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         kind_ff     <= req.kind;
         level_ff    <= req.button_level;
         new_mode_ff <= req.new_mode;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   bgm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bgm_engine #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .kind         (kind_ff),
      .button_level (level_ff),
      .new_mode     (new_mode_ff),
      .cfg          (cfg),
      .result       (result)
   );

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.led_on        = rsp_ff.led_on;
   assign rsp.mode          = rsp_ff.mode;
   assign rsp.gesture       = rsp_ff.gesture;
   assign rsp.press_count   = rsp_ff.press_count;
   assign rsp.command_count = rsp_ff.command_count;

   // a long press always leaves the block in alert mode
   a_long_alert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.gesture == bgm_pkg::GEST_LONG
         |-> rsp_ff.mode == bgm_pkg::MODE_ALERT)
      else $error("long press result not in alert mode");

   // config mode holds the led solid on
   a_config_led: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.mode == bgm_pkg::MODE_CONFIG |-> rsp_ff.led_on)
      else $error("led off in config mode");

   // a held item in the input register is never dropped
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(kind_ff))
      else $error("stalled input item lost");

   // each engine evaluation shows up as a result the next cycle
   a_fire_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("evaluated item produced no result");

endmodule

`default_nettype wire
